/* rtl/urlpd_pkg.sv */
// shared constants, queue entry type and character helpers for the url decoder
`timescale 1ns / 1ps
package urlpd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  // one queue entry: a first result and an optional second one
  // (the second always carries a byte and closes the string)
  typedef struct packed {
    logic [7:0] char0;
    logic       has0;
    logic       last0;
    logic [7:0] char1;
    logic       two;
  } urlpd_entry_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LA) begin
      v = c - CH_LA + DIGIT_TEN;
    end else if (c >= CH_UA) begin
      v = c - CH_UA + DIGIT_TEN;
    end else begin
      v = c - CH_ZERO;
    end
    return v;
  endfunction

  function automatic logic [7:0] single_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

/* rtl/urlpd_front.sv */
// front end: takes encoded bytes, tracks percent escapes and the byte budget
`timescale 1ns / 1ps
module urlpd_front
  import urlpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // in_char
  input  logic         in_tlast,   // in_last
  input  logic         q_full,
  output logic         q_push,
  output urlpd_entry_t q_entry
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] max_r;

  logic       acc;
  logic       want0, want1;
  logic       em0, em1;
  logic       cnt_lt, cnt1_lt;
  logic [7:0] ch0, ch1;
  logic [7:0] hi_val, lo_val;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  assign cnt_lt  = cnt_r < max_r;
  assign cnt1_lt = ({1'b0, cnt_r} + 9'd1) < {1'b0, max_r};
  assign hi_val  = digit_value(hi_r);
  assign lo_val  = digit_value(in_tdata);

  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    want0     = 1'b0;
    want1     = 1'b0;
    ch0       = single_byte(in_tdata);
    ch1       = single_byte(in_tdata);
    unique case (phase_r)
      PH_PCT: begin
        if (in_tlast) begin
          // escape cut off by the end: literal percent, then the byte alone
          want0 = 1'b1;
          want1 = 1'b1;
          ch0   = CH_PCT;
        end else begin
          hi_nxt    = in_tdata;
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        want0     = 1'b1;
        ch0       = {hi_val[3:0], 4'b0000} | lo_val;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_tdata == CH_PCT && !in_tlast) begin
          phase_nxt = PH_PCT;
        end else begin
          want0 = 1'b1;
        end
      end
    endcase
    if (in_tlast) begin
      phase_nxt = PH_IDLE;
      hi_nxt    = 8'd0;
    end
  end

  assign em0 = want0 && cnt_lt;
  assign em1 = want1 && cnt1_lt;

  always_comb begin
    q_entry.char1 = ch1;
    q_entry.two   = em0 && em1;
    if (em0) begin
      q_entry.char0 = ch0;
      q_entry.has0  = 1'b1;
      q_entry.last0 = in_tlast && !em1;
    end else begin
      // end-only marker after truncation
      q_entry.char0 = 8'd0;
      q_entry.has0  = 1'b0;
      q_entry.last0 = 1'b1;
    end
  end

  assign q_push  = acc && (em0 || in_tlast);
  assign cnt_nxt = in_tlast ? 8'd0 : (cnt_r + {7'd0, em0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hi_r    <= 8'd0;
      cnt_r   <= 8'd0;
      max_r   <= 8'd255;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (acc) begin
        phase_r <= phase_nxt;
        hi_r    <= hi_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> cnt_r == 8'd0 && phase_r == PH_IDLE)
    else $error("string state not cleared after last transfer");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |-> q_push && (q_entry.last0 || q_entry.two))
    else $error("last input produced no closing result");

endmodule

/* rtl/urlpd_fifo.sv */
// short queue of result entries between front and back end
`timescale 1ns / 1ps
module urlpd_fifo
  import urlpd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  urlpd_entry_t wr_entry,
  input  logic         pop,
  output urlpd_entry_t head,
  output logic         empty,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urlpd_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic do_push, do_pop;

  assign empty   = count_r == '0;
  assign full    = count_r == CW'(DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill level beyond depth");

endmodule

/* rtl/urlpd_back.sv */
// back end: expands queue entries into result transfers through an output register
`timescale 1ns / 1ps
module urlpd_back
  import urlpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  urlpd_entry_t head,
  input  logic         empty,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // out_char
  output logic         out_tuser,  // has_char
  output logic         out_tlast   // out_last
);

  logic       valid_r;
  logic       sub_r, sub_nxt;
  logic [7:0] char_r, char_nxt;
  logic       has_r, has_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_tready;

  always_comb begin
    sub_nxt  = sub_r;
    pop      = 1'b0;
    char_nxt = head.char0;
    has_nxt  = head.has0;
    last_nxt = head.last0;
    if (load && !empty) begin
      if (sub_r) begin
        // second half of a cut-off escape
        char_nxt = head.char1;
        has_nxt  = 1'b1;
        last_nxt = 1'b1;
        sub_nxt  = 1'b0;
        pop      = 1'b1;
      end else if (head.two) begin
        sub_nxt = 1'b1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      has_r  <= has_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        valid_r <= !empty;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tuser  = has_r;
  assign out_tlast  = last_r;

  a_sub_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> !empty && head.two)
    else $error("second result pending without a paired entry");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !has_r |-> last_r && char_r == 8'd0)
    else $error("marker result not closing or not zero");

  a_pair_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    load && !empty && head.two && !sub_r |=> valid_r && has_r && !last_r)
    else $error("first of a pair must carry a byte and stay open");

endmodule

/* rtl/url_percent_decoder_core.sv */
// top level of the streaming url percent decoder
// an input transfer is written into the queue, then loaded into the output register (queue empty, sink ready)
// throughput: one input byte per cycle while the queue is not full; a cut-off escape at the end of a string
//   gives two results from one queue entry, and the output side sends both before it pops that entry
// the output register and the queue (FIFO_DEPTH entries) let both sides stall independently
// reset (rst_n low, synchronous) empties queue and output, max_chars returns to 255
`timescale 1ns / 1ps
module url_percent_decoder_core
  import urlpd_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,   // max_chars
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_char
  input  logic       in_tlast,    // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_char
  output logic       out_tuser,   // has_char
  output logic       out_tlast    // out_last
);

  urlpd_entry_t wr_entry, head;
  logic push, pop, empty, full;

  urlpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (wr_entry)
  );

  urlpd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  urlpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
